// File: design/dsc_pkg.sv
// package: shared constants, op codes and the table write bundle for the safety check
`timescale 1ns / 1ps
package dsc_pkg;

	// parameter defaults
	localparam int DEF_MAX_PROCESSES = 16;
	localparam int DEF_MAX_RESOURCES = 8;
	localparam int DEF_COUNT_BITS    = 16;

	// field widths fixed by the port list
	localparam int OP_W    = 2;
	localparam int PROC_W  = 4;
	localparam int RES_W   = 3;
	localparam int VALUE_W = 16;
	localparam int CFG_W   = 5;
	localparam int PCNT_W  = 5;
	localparam int RCNT_W  = 4;

	// register indexes
	localparam logic CFG_PROCESS_COUNT  = 1'b0;
	localparam logic CFG_RESOURCE_COUNT = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_WR_MAX   = 2'd0,
		OP_WR_ALLOC = 2'd1,
		OP_WR_AVAIL = 2'd2,
		OP_RUN      = 2'd3
	} op_t;

	// table write broadcast to every resource cell
	typedef struct packed {
		logic               we_max;
		logic               we_alloc;
		logic               we_avail;
		logic [PROC_W-1:0]  row;
		logic [RES_W-1:0]   col;
		logic [VALUE_W-1:0] data;
	} dsc_wr_t;

endpackage

// File: design/dsc_cell.sv
// resource cell: one column of claim and allocation, one available counter, fit chain link
`timescale 1ns / 1ps
module dsc_cell import dsc_pkg::*; #(
	parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
	parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
	parameter int COUNT_BITS    = DEF_COUNT_BITS,
	parameter int CELL_INDEX    = 0,
	localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
	localparam int RW = $clog2(MAX_RESOURCES + 1),
	localparam int AW = COUNT_BITS + 4
) (
	input  logic          clk,
	input  dsc_wr_t       wr,
	input  logic [PW-1:0] rd_row,
	input  logic [RW-1:0] rc,
	input  logic          upd,
	input  logic          fit_in,
	output logic          fit_out
);

	logic [COUNT_BITS-1:0] max_q   [MAX_PROCESSES];
	logic [COUNT_BITS-1:0] alloc_q [MAX_PROCESSES];
	logic [AW-1:0]         avail_q;

	logic [COUNT_BITS-1:0] max_rd, alloc_rd, need;
	logic [AW:0]           sum;
	logic                  col_hit, active, short;

	assign col_hit  = (wr.col == CELL_INDEX);
	assign active   = (rc > CELL_INDEX);
	assign max_rd   = max_q[rd_row];
	assign alloc_rd = alloc_q[rd_row];
	assign need     = max_rd - alloc_rd;

	// positive need above what is available blocks the process
	assign short   = (max_rd > alloc_rd) && (AW'(need) > avail_q);
	assign fit_out = fit_in & (~active | ~short);

	// released allocation, saturating
	assign sum = {1'b0, avail_q} + (AW + 1)'(alloc_rd);

	// table writes
	always_ff @(posedge clk) begin
		if (wr.we_max && col_hit) begin
			max_q[PW'(wr.row)] <= COUNT_BITS'(wr.data);
		end
		if (wr.we_alloc && col_hit) begin
			alloc_q[PW'(wr.row)] <= COUNT_BITS'(wr.data);
		end
	end

	// available counter
	always_ff @(posedge clk) begin
		if (wr.we_avail && col_hit) begin
			avail_q <= AW'(COUNT_BITS'(wr.data));
		end else if (upd && active) begin
			avail_q <= sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
		end
	end

endmodule

// File: design/deadlock_safety_check.sv
// top level: banker's safety check, sequencer over a chain of resource cells
// loads give no result
// a run steps one process per cycle, through the single scan pointer shared by all cells;
// one result per process in use
// busy is high while a run is in progress; results carry a one-cycle strobe
// reset clears the sequencer and finished marks and sets the counts (16 processes, 8 resources)
`timescale 1ns / 1ps
module deadlock_safety_check import dsc_pkg::*; #(
	parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
	parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
	parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [OP_W-1:0]    op,
	input  logic [PROC_W-1:0]  process_index,
	input  logic [RES_W-1:0]   resource_index,
	input  logic [VALUE_W-1:0] value,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               result_valid,
	output logic [PROC_W-1:0]  process_id,
	output logic               finished,
	output logic               last,
	output logic               system_safe
);

	localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CW = $clog2(MAX_PROCESSES + 1);
	localparam int RW = $clog2(MAX_RESOURCES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_REPORT} state_t;

	state_t                   state_q;
	logic [PCNT_W-1:0]        process_count_q;
	logic [RCNT_W-1:0]        resource_count_q;
	logic [MAX_PROCESSES-1:0] done_q;
	logic [CW-1:0]            idx_q, cnt_q;

	logic [CW-1:0]            pc;
	logic [RW-1:0]            rc;
	logic [MAX_PROCESSES-1:0] in_use, undone;
	logic [PW-1:0]            row;
	logic                     accept, cur_done, fit_all, at_end, none_above, take, final_take;
	logic [MAX_RESOURCES:0]   fit;
	dsc_wr_t                  wr;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;

	// clamped counts
	always_comb begin
		if (process_count_q == '0) pc = CW'(1);
		else if (process_count_q > MAX_PROCESSES) pc = CW'(MAX_PROCESSES);
		else pc = CW'(process_count_q);
		if (resource_count_q == '0) rc = RW'(1);
		else if (resource_count_q > MAX_RESOURCES) rc = RW'(MAX_RESOURCES);
		else rc = RW'(resource_count_q);
	end

	// processes in use and still unfinished
	always_comb begin
		for (int j = 0; j < MAX_PROCESSES; j++) begin
			in_use[j] = (j < pc);
		end
	end
	assign undone     = ~done_q & in_use;
	assign none_above = (((undone >> idx_q) >> 1) == '0);

	assign row      = PW'(idx_q);
	assign at_end   = (idx_q >= pc);
	assign cur_done = done_q[row];
	assign take       = (state_q == ST_SCAN) && !at_end && !cur_done && fit_all;
	assign final_take = ((cnt_q + CW'(1)) == pc);

	// table write broadcast
	always_comb begin
		wr.row      = process_index;
		wr.col      = resource_index;
		wr.data     = value;
		wr.we_avail = accept && (op == OP_WR_AVAIL);
		wr.we_max   = accept && (op == OP_WR_MAX) && (process_index < MAX_PROCESSES);
		wr.we_alloc = accept && (op == OP_WR_ALLOC) && (process_index < MAX_PROCESSES);
	end

	// chain of resource cells
	assign fit[0]  = 1'b1;
	assign fit_all = fit[MAX_RESOURCES];

	for (genvar k = 0; k < MAX_RESOURCES; k++) begin : g_cell
		dsc_cell #(
			.MAX_PROCESSES(MAX_PROCESSES),
			.MAX_RESOURCES(MAX_RESOURCES),
			.COUNT_BITS   (COUNT_BITS),
			.CELL_INDEX   (k)
		) u_cell (
			.clk    (clk),
			.wr     (wr),
			.rd_row (row),
			.rc     (rc),
			.upd    (take),
			.fit_in (fit[k]),
			.fit_out(fit[k+1])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q  <= PCNT_W'(16);
			resource_count_q <= RCNT_W'(8);
		end else if (cfg_we) begin
			if (cfg_index == CFG_PROCESS_COUNT) process_count_q <= cfg_data;
			else resource_count_q <= cfg_data[RCNT_W-1:0];
		end
	end

	// sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (op == OP_RUN)) begin
						done_q  <= '0;
						idx_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (at_end) begin
						idx_q   <= '0;
						state_q <= ST_REPORT;
					end else if (take) begin
						done_q[row]  <= 1'b1;
						cnt_q        <= cnt_q + CW'(1);
						idx_q        <= '0;
						result_valid <= 1'b1;
						process_id   <= PROC_W'(idx_q);
						finished     <= 1'b1;
						last         <= final_take;
						system_safe  <= final_take;
						if (final_take) state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_REPORT: begin
					if (at_end) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + CW'(1);
						if (!cur_done) begin
							result_valid <= 1'b1;
							process_id   <= PROC_W'(idx_q);
							finished     <= 1'b0;
							last         <= none_above;
							system_safe  <= 1'b0;
							if (none_above) state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
